// ----- rtl/core/cpgr_pkg.sv -----
package cpgr_pkg;

  typedef enum logic [1:0] {
    FUNC_SAMPLE    = 2'd0,
    FUNC_DIRECTION = 2'd1,
    FUNC_DISTANCE  = 2'd2,
    FUNC_NONE      = 2'd3
  } func_e;

  typedef struct packed {
    func_e              func;
    logic signed [23:0] sample;
    logic [16:0]        setting;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMP_GAIN,
    ST_SMP_MUL,
    ST_SMP_EMIT,
    ST_POS,
    ST_FOLD,
    ST_DIST,
    ST_RAD,
    ST_SQRT,
    ST_SCALE,
    ST_DIFF,
    ST_DIV
  } state_e;

  typedef enum logic {
    REG_NUM_OUTPUTS  = 1'b0,
    REG_RAMP_SAMPLES = 1'b1
  } reg_e;

  localparam int unsigned        MaxOutputs  = 8;
  localparam logic [16:0]        SetOne      = 17'd65536;
  localparam logic signed [31:0] GainOne     = 32'sd1073741824;
  localparam logic [3:0]         NumOutReset = 4'd8;
  localparam logic [15:0]        RampReset   = 16'd2400;

endpackage

// ----- rtl/core/cpgr_front.sv -----
module cpgr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  cpgr_pkg::item_t     s_item_i,
  output cpgr_pkg::qhead_t    head_o,
  input  logic                pop_i
);

  cpgr_pkg::item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;

  // Items of unknown kind are taken and dropped here.
  assign s_ready_o = (cnt_q != 2'd2);
  assign push = s_valid_i && s_ready_o && (s_item_i.func != cpgr_pkg::FUNC_NONE);
  assign pop  = pop_i && (cnt_q != 2'd0);

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = 2'(cnt_q + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= s_item_i;
    end
  end

endmodule

// ----- rtl/core/cpgr_sqrt.sv -----
module cpgr_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [61:0] rad_i,
  output logic        done_o,
  output logic [30:0] root_o
);

  logic [61:0] rad_q, rad_d;
  logic [33:0] rem_q, rem_d;
  logic [30:0] root_q, root_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [33:0] rem_sh;
  logic [33:0] trial;

  assign rem_sh = {rem_q[31:0], rad_q[61:60]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign done_o = done_q;
  assign root_o = root_q;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = 5'd30;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[59:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[29:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[29:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

endmodule

// ----- rtl/core/cpgr_div.sv -----
module cpgr_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [16:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quo_o
);

  logic [31:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [16:0] dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [17:0] rem_sh;

  assign rem_sh = {rem_q, quo_q[31]};
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = 5'd31;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = 17'(rem_sh - {1'b0, dvs_q});
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = rem_sh[16:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

endmodule

// ----- rtl/core/cpgr_back.sv -----
module cpgr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cpgr_pkg::qhead_t    head_i,
  output logic                pop_o,
  input  logic [3:0]          num_outputs_i,
  input  logic [15:0]         ramp_samples_i,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [2:0]          m_chan_o,
  output logic signed [23:0]  m_data_o,
  output logic                m_last_o
);

  localparam int unsigned CW   = $clog2(cpgr_pkg::MaxOutputs);
  localparam int unsigned NW   = $clog2(cpgr_pkg::MaxOutputs + 1);
  localparam int unsigned CMPW = (NW > 4) ? NW : 4;
  localparam int unsigned PW   = NW + 18;
  localparam int unsigned TW   = PW + 17;
  localparam logic [TW-1:0] OneT = TW'(1) << 32;

  cpgr_pkg::state_e state_q, state_d;

  logic [15:0]        direction_q;
  logic [16:0]        distance_q;
  logic [15:0]        ramp_cnt_q;
  logic               ramping_q;
  logic [CW-1:0]      ch_q;
  logic signed [23:0] smp_q;
  logic signed [31:0] gain_q;
  logic signed [55:0] prod_q;
  logic [PW-1:0]      psum_q;
  logic [PW-1:0]      a_q;
  logic [32:0]        v_q;
  logic signed [31:0] tgt_new_q;
  logic               neg_q;

  logic signed [31:0] cur_q  [cpgr_pkg::MaxOutputs];
  logic signed [31:0] tgt_q  [cpgr_pkg::MaxOutputs];
  logic signed [31:0] step_q [cpgr_pkg::MaxOutputs];

  logic               out_valid_q;
  logic [2:0]         out_chan_q;
  logic signed [23:0] out_data_q;
  logic               out_last_q;

  logic [CMPW-1:0]    nout_ext;
  logic [NW-1:0]      n;
  logic [CW-1:0]      last_ch;
  logic               is_two;
  logic               is_last;
  logic               out_load;
  logic               sqrt_start;
  logic               div_start;
  logic               sqrt_done;
  logic               div_done;
  logic [30:0]        root;
  logic [31:0]        quo;
  logic [61:0]        rad;
  logic [31:0]        mag;
  logic [32:0]        diff;
  logic [17:0]        scale;
  logic [NW-1:0]      place;
  logic [PW-1:0]      turn;
  logic [PW-1:0]      mid;
  logic [PW-1:0]      p1;
  logic [PW-1:0]      p2;
  logic [TW-1:0]      t;
  logic [50:0]        vs;
  logic [48:0]        r_scaled;
  logic [48:0]        r_clamped;
  logic [32:0]        g_sum;
  logic signed [31:0] g_new;
  logic signed [25:0] q26;
  logic signed [23:0] q_sat;

  always_comb begin
    nout_ext = CMPW'(num_outputs_i);
    if (nout_ext < CMPW'(2)) begin
      n = NW'(2);
    end else if (nout_ext > CMPW'(cpgr_pkg::MaxOutputs)) begin
      n = NW'(cpgr_pkg::MaxOutputs);
    end else begin
      n = NW'(nout_ext);
    end
  end

  assign last_ch = CW'(n - NW'(1));
  assign is_two  = (n == NW'(2));
  assign is_last = (ch_q == last_ch);
  assign scale   = 18'(distance_q) + 18'(cpgr_pkg::SetOne);

  // Circle position in units of 1/(n*65536) turn, folded around the half turn.
  always_comb begin
    place = (ch_q == '0) ? '0 : NW'(n - NW'(ch_q));
    turn  = PW'(n) << 16;
    mid   = PW'(n) << 15;
    p1    = (psum_q >= turn) ? PW'(psum_q - turn) : psum_q;
    p2    = (p1 >= turn) ? PW'(p1 - turn) : p1;
  end

  assign t  = TW'(a_q) * TW'(distance_q);
  assign vs = 51'(v_q) * 51'(scale);
  assign rad = is_two ? {vs, 11'b0} : {1'b0, v_q, 28'b0};

  always_comb begin
    if (is_two) begin
      r_scaled = 49'(root);
    end else begin
      r_scaled = (49'(root) * 49'(scale)) >> 17;
    end
    r_clamped = (r_scaled > 49'(cpgr_pkg::GainOne)) ? 49'(cpgr_pkg::GainOne) : r_scaled;
  end

  assign diff = {tgt_q[ch_q][31], tgt_q[ch_q]} - {cur_q[ch_q][31], cur_q[ch_q]};
  assign mag  = diff[32] ? 32'(-diff) : diff[31:0];

  always_comb begin
    g_sum = {cur_q[ch_q][31], cur_q[ch_q]} + {step_q[ch_q][31], step_q[ch_q]};
    if (!ramping_q) begin
      g_new = tgt_q[ch_q];
    end else if (g_sum[32] != g_sum[31]) begin
      g_new = g_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      g_new = g_sum[31:0];
    end
  end

  always_comb begin
    q26 = prod_q[55:30];
    if (q26[25:23] == 3'b000 || q26[25:23] == 3'b111) begin
      q_sat = q26[23:0];
    end else begin
      q_sat = q26[25] ? 24'sh800000 : 24'sh7FFFFF;
    end
  end

  assign out_load = (state_q == cpgr_pkg::ST_SMP_EMIT) && (!out_valid_q || m_ready_i);

  always_comb begin
    state_d    = state_q;
    pop_o      = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      cpgr_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          state_d = (head_i.item.func == cpgr_pkg::FUNC_SAMPLE) ? cpgr_pkg::ST_SMP_GAIN
                                                                 : cpgr_pkg::ST_POS;
        end
      end
      cpgr_pkg::ST_SMP_GAIN: state_d = cpgr_pkg::ST_SMP_MUL;
      cpgr_pkg::ST_SMP_MUL:  state_d = cpgr_pkg::ST_SMP_EMIT;
      cpgr_pkg::ST_SMP_EMIT: begin
        if (out_load) begin
          state_d = is_last ? cpgr_pkg::ST_IDLE : cpgr_pkg::ST_SMP_GAIN;
        end
      end
      cpgr_pkg::ST_POS:  state_d = cpgr_pkg::ST_FOLD;
      cpgr_pkg::ST_FOLD: state_d = cpgr_pkg::ST_DIST;
      cpgr_pkg::ST_DIST: state_d = cpgr_pkg::ST_RAD;
      cpgr_pkg::ST_RAD: begin
        sqrt_start = 1'b1;
        state_d = cpgr_pkg::ST_SQRT;
      end
      cpgr_pkg::ST_SQRT: begin
        if (sqrt_done) begin
          state_d = cpgr_pkg::ST_SCALE;
        end
      end
      cpgr_pkg::ST_SCALE: state_d = cpgr_pkg::ST_DIFF;
      cpgr_pkg::ST_DIFF: begin
        div_start = 1'b1;
        state_d = cpgr_pkg::ST_DIV;
      end
      cpgr_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = is_last ? cpgr_pkg::ST_IDLE : cpgr_pkg::ST_POS;
        end
      end
      default: state_d = cpgr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpgr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= '0;
      distance_q  <= cpgr_pkg::SetOne;
      ramp_cnt_q  <= cpgr_pkg::RampReset;
      ramping_q   <= 1'b0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < cpgr_pkg::MaxOutputs; i++) begin
        cur_q[i]  <= (i == 0) ? cpgr_pkg::GainOne : '0;
        tgt_q[i]  <= (i == 0) ? cpgr_pkg::GainOne : '0;
        step_q[i] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        cpgr_pkg::ST_IDLE: begin
          ch_q <= '0;
          if (head_i.valid) begin
            unique case (head_i.item.func)
              cpgr_pkg::FUNC_SAMPLE: begin
                ramping_q <= (ramp_cnt_q != '0);
                if (ramp_cnt_q != '0) begin
                  ramp_cnt_q <= ramp_cnt_q - 16'd1;
                end
              end
              cpgr_pkg::FUNC_DIRECTION: direction_q <= head_i.item.setting[15:0];
              cpgr_pkg::FUNC_DISTANCE: begin
                distance_q <= (head_i.item.setting > cpgr_pkg::SetOne) ? cpgr_pkg::SetOne
                                                                      : head_i.item.setting;
              end
              default: ;
            endcase
          end
        end
        cpgr_pkg::ST_SMP_GAIN: cur_q[ch_q] <= g_new;
        cpgr_pkg::ST_SMP_EMIT: begin
          if (out_load && !is_last) begin
            ch_q <= ch_q + CW'(1);
          end
        end
        cpgr_pkg::ST_SCALE: tgt_q[ch_q] <= 32'(r_clamped);
        cpgr_pkg::ST_DIV: begin
          if (div_done) begin
            step_q[ch_q] <= neg_q ? 32'(-quo) : quo;
            if (is_last) begin
              ramp_cnt_q <= ramp_samples_i;
            end else begin
              ch_q <= ch_q + CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == cpgr_pkg::ST_IDLE) begin
      smp_q <= head_i.item.sample;
    end
    if (state_q == cpgr_pkg::ST_SMP_GAIN) begin
      gain_q <= g_new;
    end
    if (state_q == cpgr_pkg::ST_SMP_MUL) begin
      prod_q <= 56'(smp_q) * 56'(gain_q);
    end
    if (state_q == cpgr_pkg::ST_POS) begin
      psum_q <= PW'(direction_q) * PW'(n) + mid + (PW'(place) << 16);
    end
    if (state_q == cpgr_pkg::ST_FOLD) begin
      a_q <= (p2 >= mid) ? PW'(p2 - mid) : PW'(mid - p2);
    end
    if (state_q == cpgr_pkg::ST_DIST) begin
      v_q <= (t >= OneT) ? '0 : 33'(OneT - t);
    end
    if (state_q == cpgr_pkg::ST_SCALE) begin
      tgt_new_q <= 32'(r_clamped);
    end
    if (state_q == cpgr_pkg::ST_DIFF) begin
      neg_q <= diff[32];
    end
    if (out_load) begin
      out_chan_q <= 3'(ch_q);
      out_data_q <= q_sat;
      out_last_q <= is_last;
    end
  end

  cpgr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (rad),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  cpgr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start && (tgt_new_q == tgt_q[ch_q])),
    .dividend_i (mag),
    .divisor_i  (17'(ramp_samples_i) + 17'd1),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  assign m_valid_o = out_valid_q;
  assign m_chan_o  = out_chan_q;
  assign m_data_o  = out_data_q;
  assign m_last_o  = out_last_q;

endmodule

// ----- rtl/core/circular_panner_gain_ramp.sv -----
// Channel    Direction  Handshake                    Payload
// s_axis     in         s_axis_tvalid/s_axis_tready  tuser func, tdata sample and setting
// m_axis     out        m_axis_tvalid/m_axis_tready  tuser channel, tdata gain_output, tlast
// cfg        in         cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// A sample item runs gain, multiply and emit steps for each active channel in turn.
// A direction or distance item runs, for each active channel, position, fold, distance and
// radicand steps, then the square root and the step divider, which run in turn.
// Reset leaves the gains at channel 0 full scale and the others silent.
// A two-entry queue takes up to two items while the output register is stalled.
module circular_panner_gain_ramp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // sample [23:0], setting [40:24], zero [47:41]
  input  logic [1:0]  s_axis_tuser,  // func [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // gain_output [23:0]
  output logic [2:0]  m_axis_tuser,  // channel [2:0]
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [3:0]       num_outputs_q;
  logic [15:0]      ramp_samples_q;
  cpgr_pkg::item_t  s_item;
  cpgr_pkg::qhead_t head;
  logic             pop;
  logic signed [23:0] m_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_outputs_q  <= cpgr_pkg::NumOutReset;
      ramp_samples_q <= cpgr_pkg::RampReset;
    end else if (cfg_we_i) begin
      unique case (cpgr_pkg::reg_e'(cfg_idx_i))
        cpgr_pkg::REG_NUM_OUTPUTS:  num_outputs_q  <= cfg_wdata_i[3:0];
        cpgr_pkg::REG_RAMP_SAMPLES: ramp_samples_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    s_item.func    = cpgr_pkg::func_e'(s_axis_tuser);
    s_item.sample  = s_axis_tdata[23:0];
    s_item.setting = s_axis_tdata[40:24];
  end

  cpgr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_item_i  (s_item),
    .head_o    (head),
    .pop_i     (pop)
  );

  cpgr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .num_outputs_i  (num_outputs_q),
    .ramp_samples_i (ramp_samples_q),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .m_chan_o       (m_axis_tuser),
    .m_data_o       (m_data),
    .m_last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = m_data;

endmodule

// ----- rtl/core/cpgr_checker.sv -----
module cpgr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic [2:0] exp_chan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_chan_q <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      exp_chan_q <= m_axis_tlast ? 3'd0 : exp_chan_q + 3'd1;
    end
  end

  // Results of one sample come in channel order, starting at channel zero.
  a_chan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == exp_chan_q))
    else $error("output channel out of order");

  // At least two channels are active, so the closing transfer is never channel zero.
  a_last_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser != 3'd0))
    else $error("last flag on channel zero");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

endmodule

bind circular_panner_gain_ramp cpgr_checker u_cpgr_checker (.*);
